// File: sv/lcsl_pkg.sv
// ---------------------------------------------------------------------------
// lcsl_pkg: shared types for the LCS length and traceback core
// Word formats of the command and result ports, and the command and status
// groups that join the controller to the datapath.
// ---------------------------------------------------------------------------
package lcsl_pkg;

	// Operation codes carried in the op field of an input word.
	localparam logic OP_LOAD_A = 1'b0;
	localparam logic OP_LOAD_B = 1'b1;

	// One input word: an element for sequence A or B.
	typedef struct packed {
		logic              op;
		logic signed [31:0] element;
		logic              final_element;
	} lcsl_in_t;

	// One result word: one element of the common subsequence.
	typedef struct packed {
		logic [5:0]         common_length;
		logic signed [31:0] match_value;
		logic               match_valid;
		logic               overflowed;
		logic               run_end;
	} lcsl_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic fill;
		logic tb_init;
		logic tb_read;
		logic tb_step;
		logic emit;
		logic emit_empty;
		logic clear;
	} lcsl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic closing;
		logic fill_last;
		logic tb_end;
		logic len_zero;
		logic emit_last;
	} lcsl_stat_t;

endpackage

// File: sv/lcsl_ctrl.sv
// ---------------------------------------------------------------------------
// lcsl_ctrl: sequencing controller
// Steps one run through loading, table fill, traceback and result output.
// ---------------------------------------------------------------------------
module lcsl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output lcsl_pkg::lcsl_cmd_t cmd,
	input  lcsl_pkg::lcsl_stat_t stat
);
	import lcsl_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_FILL     = 3'd1;
	localparam logic [2:0] S_FILL_END = 3'd2;
	localparam logic [2:0] S_TB_RD    = 3'd3;
	localparam logic [2:0] S_TB_DEC   = 3'd4;
	localparam logic [2:0] S_EMIT     = 3'd5;
	localparam logic [2:0] S_EMPTY    = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start && stat.closing) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					state_d = S_FILL_END;
				end
			end
			S_FILL_END: begin
				cmd.tb_init = 1'b1;
				state_d     = S_TB_RD;
			end
			S_TB_RD: begin
				cmd.tb_read = 1'b1;
				state_d     = S_TB_DEC;
			end
			S_TB_DEC: begin
				cmd.tb_step = 1'b1;
				if (stat.tb_end) begin
					state_d = stat.len_zero ? S_EMPTY : S_EMIT;
				end else begin
					state_d = S_TB_RD;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last) begin
					state_d = S_DONE;
				end
			end
			S_EMPTY: begin
				cmd.emit_empty = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				cmd.clear = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: sv/lcsl_dp.sv
// ---------------------------------------------------------------------------
// lcsl_dp: datapath of the LCS core
// Sequence stores, score table, fill pipeline, traceback walk and the
// trace buffer that feeds the result port.
// ---------------------------------------------------------------------------
module lcsl_dp #(
	parameter int MAX_LEN = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcsl_pkg::lcsl_cmd_t  cmd,
	output lcsl_pkg::lcsl_stat_t stat,
	input  lcsl_pkg::lcsl_in_t   item,
	output lcsl_pkg::lcsl_out_t  result,
	output logic                 strobe
);
	import lcsl_pkg::*;

	localparam int IW  = $clog2(MAX_LEN + 1);
	localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int TD  = MAX_LEN + 1;
	localparam int TAW = $clog2(TD * TD);
	localparam logic [TAW-1:0] TD_W = TAW'(TD);
	localparam logic [IW-1:0]  MAX_W = IW'(MAX_LEN);

	// Row-major address of table cell (r, c).
	function automatic logic [TAW-1:0] taddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return TAW'(r) * TD_W + TAW'(c);
	endfunction

	// Storage.
	logic signed [31:0] seq_a_mem [MAX_LEN];
	logic signed [31:0] seq_b_mem [MAX_LEN];
	logic signed [31:0] tbuf_mem  [MAX_LEN];
	logic [IW-1:0]      score_mem [TD * TD];

	// Load state.
	logic [IW-1:0] count_a_q, count_b_q;
	logic          closed_a_q, closed_b_q, ovf_q;

	// Fill issue position and pipeline stage.
	logic [IW-1:0] ri_q, rj_q;
	logic          valid_s1, last_s1, upz_s1, fwd_s1;
	logic [IW-1:0] i_s1, j_s1;
	logic [IW-1:0] left_q, diag_q;

	// Traceback and output state.
	logic [IW-1:0] ti_q, tj_q, tk_q, ek_q, len_q;
	logic          tb_upz_q, tb_lz_q;
	logic          out_valid_s1, out_empty_s1, out_last_s1;

	// Registered memory read data.
	logic signed [31:0] a_rd_q, b_rd_q, tbuf_rd_q;
	logic [IW-1:0]      t_rd0_q, t_rd1_q;

	// Load decode for the word on the command port.
	logic          sel_closed, other_closed, room, take;
	logic [IW-1:0] sel_cnt;

	always_comb begin
		sel_closed   = (item.op == OP_LOAD_B) ? closed_b_q : closed_a_q;
		other_closed = (item.op == OP_LOAD_B) ? closed_a_q : closed_b_q;
		sel_cnt      = (item.op == OP_LOAD_B) ? count_b_q : count_a_q;
		room         = (sel_cnt < MAX_W);
		take         = cmd.load && !sel_closed;
	end

	// Read addresses are shared by the fill and the traceback.
	logic [IW-1:0]  rd_row, rd_col;
	logic [TAW-1:0] t_addr0, t_addr1;
	logic           rd_en;

	always_comb begin
		rd_row  = cmd.fill ? ri_q : ti_q;
		rd_col  = cmd.fill ? rj_q : tj_q;
		t_addr0 = taddr(rd_row - 1'b1, rd_col);
		t_addr1 = taddr(ti_q, tj_q - 1'b1);
		rd_en   = cmd.fill || cmd.tb_read;
	end

	// Fill compute stage: one table cell per cycle.
	logic [IW-1:0] f_up, f_left, f_diag, f_val;
	logic          f_first, elem_eq;

	always_comb begin
		elem_eq = (a_rd_q == b_rd_q);
		f_first = (j_s1 == IW'(1));
		f_up    = upz_s1 ? '0 : (fwd_s1 ? left_q : t_rd0_q);
		f_left  = f_first ? '0 : left_q;
		f_diag  = f_first ? '0 : diag_q;
		if (elem_eq) begin
			f_val = f_diag + IW'(1);
		end else begin
			f_val = (f_up > f_left) ? f_up : f_left;
		end
	end

	// Traceback decision on the cells around the current corner.
	logic [IW-1:0] t_up, t_left;
	logic          t_go_up;

	always_comb begin
		t_up    = tb_upz_q ? '0 : t_rd0_q;
		t_left  = tb_lz_q ? '0 : t_rd1_q;
		t_go_up = (t_up > t_left);
	end

	// Status back to the controller.
	always_comb begin
		stat.closing   = !sel_closed && item.final_element && other_closed;
		stat.fill_last = (ri_q == count_a_q) && (rj_q == count_b_q);
		if (elem_eq) begin
			stat.tb_end = (ti_q == IW'(1)) || (tj_q == IW'(1));
		end else if (t_go_up) begin
			stat.tb_end = (ti_q == IW'(1));
		end else begin
			stat.tb_end = (tj_q == IW'(1));
		end
		stat.len_zero  = (len_q == '0);
		stat.emit_last = (ek_q == len_q - 1'b1);
	end

	// Load counters, closing flags and overflow mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			closed_a_q <= 1'b0;
			closed_b_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (cmd.clear) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			closed_a_q <= 1'b0;
			closed_b_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (take) begin
			if (!room) begin
				ovf_q <= 1'b1;
			end else if (item.op == OP_LOAD_B) begin
				count_b_q <= count_b_q + 1'b1;
			end else begin
				count_a_q <= count_a_q + 1'b1;
			end
			if (item.final_element) begin
				if (item.op == OP_LOAD_B) begin
					closed_b_q <= 1'b1;
				end else begin
					closed_a_q <= 1'b1;
				end
			end
		end
	end

	// Sequence store writes.
	always_ff @(posedge clk) begin
		if (take && room) begin
			if (item.op == OP_LOAD_B) begin
				seq_b_mem[count_b_q[AW-1:0]] <= item.element;
			end else begin
				seq_a_mem[count_a_q[AW-1:0]] <= item.element;
			end
		end
	end

	// Registered reads of the sequence stores and score table.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_rd_q  <= seq_a_mem[rd_row[AW-1:0] - 1'b1];
			b_rd_q  <= seq_b_mem[rd_col[AW-1:0] - 1'b1];
			t_rd0_q <= score_mem[t_addr0];
			t_rd1_q <= score_mem[t_addr1];
		end
	end

	// Score table write from the fill stage.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			score_mem[taddr(i_s1, j_s1)] <= f_val;
		end
	end

	// Fill issue walk and compute pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q     <= IW'(1);
			rj_q     <= IW'(1);
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			upz_s1   <= 1'b0;
			fwd_s1   <= 1'b0;
			i_s1     <= '0;
			j_s1     <= '0;
			left_q   <= '0;
			diag_q   <= '0;
			len_q    <= '0;
		end else begin
			valid_s1 <= cmd.fill;
			if (cmd.load) begin
				ri_q <= IW'(1);
				rj_q <= IW'(1);
			end else if (cmd.fill) begin
				i_s1    <= ri_q;
				j_s1    <= rj_q;
				last_s1 <= stat.fill_last;
				upz_s1  <= (ri_q == IW'(1));
				// The cell above was written in this very cycle (one-column table).
				fwd_s1  <= valid_s1 && (i_s1 == ri_q - 1'b1) && (j_s1 == rj_q);
				if (rj_q == count_b_q) begin
					rj_q <= IW'(1);
					ri_q <= ri_q + 1'b1;
				end else begin
					rj_q <= rj_q + 1'b1;
				end
			end
			if (valid_s1) begin
				left_q <= f_val;
				diag_q <= f_up;
				if (last_s1) begin
					len_q <= f_val;
				end
			end
		end
	end

	// Traceback walk and output index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q     <= '0;
			tj_q     <= '0;
			tk_q     <= '0;
			ek_q     <= '0;
			tb_upz_q <= 1'b0;
			tb_lz_q  <= 1'b0;
		end else begin
			if (cmd.tb_init) begin
				ti_q <= count_a_q;
				tj_q <= count_b_q;
				tk_q <= f_val;
				ek_q <= '0;
			end
			if (cmd.tb_read) begin
				tb_upz_q <= (ti_q == IW'(1));
				tb_lz_q  <= (tj_q == IW'(1));
			end
			if (cmd.tb_step) begin
				if (elem_eq) begin
					if (tk_q != '0) begin
						tk_q <= tk_q - 1'b1;
					end
					ti_q <= ti_q - 1'b1;
					tj_q <= tj_q - 1'b1;
				end else if (t_go_up) begin
					ti_q <= ti_q - 1'b1;
				end else begin
					tj_q <= tj_q - 1'b1;
				end
			end
			if (cmd.emit) begin
				ek_q <= ek_q + 1'b1;
			end
		end
	end

	// Trace buffer: filled back to front, read front to back.
	logic [IW-1:0] tk_dec;

	assign tk_dec = tk_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.tb_step && elem_eq && (tk_q != '0)) begin
			tbuf_mem[tk_dec[AW-1:0]] <= a_rd_q;
		end
		if (cmd.emit) begin
			tbuf_rd_q <= tbuf_mem[ek_q[AW-1:0]];
		end
	end

	// Output word stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
			out_empty_s1 <= 1'b0;
			out_last_s1  <= 1'b0;
		end else begin
			out_valid_s1 <= cmd.emit || cmd.emit_empty;
			if (cmd.emit) begin
				out_empty_s1 <= 1'b0;
				out_last_s1  <= stat.emit_last;
			end else if (cmd.emit_empty) begin
				out_empty_s1 <= 1'b1;
				out_last_s1  <= 1'b1;
			end
		end
	end

	always_comb begin
		result.common_length = 6'(len_q);
		result.match_value   = out_empty_s1 ? '0 : tbuf_rd_q;
		result.match_valid   = !out_empty_s1;
		result.overflowed    = ovf_q;
		result.run_end       = out_last_s1;
	end

	assign strobe = out_valid_s1;

endmodule

// File: sv/lcs_length_and_traceback_core.sv
// ---------------------------------------------------------------------------
// lcs_length_and_traceback_core: longest common subsequence with traceback
// Loads two sequences, fills the score table, walks back from the far corner
// and returns the common subsequence in forward order.
// ---------------------------------------------------------------------------
// A load word is taken while start is high and busy is low. The word that
// closes the second sequence starts the run: the table fill computes one
// cell per cycle, reading the cell above through the first of the two
// score-table read ports; each traceback step is a table read, then a
// decision; the results follow one per cycle, and busy drops in the
// cycle after the last result word. Result words appear for exactly one
// cycle with strobe high and cannot be stalled, so the receiver must
// take every word. An empty common subsequence yields one word with
// match_valid low.
module lcs_length_and_traceback_core #(
	parameter int MAX_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lcsl_pkg::lcsl_in_t  item,
	output lcsl_pkg::lcsl_out_t result,
	output logic                strobe
);
	import lcsl_pkg::*;

	lcsl_cmd_t  cmd;
	lcsl_stat_t stat;

	// Run sequencing.
	lcsl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Storage and arithmetic.
	lcsl_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.item   (item),
		.result (result),
		.strobe (strobe)
	);

endmodule
